/* rtl/rse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Shared widths, command codes and types of the retroactive stack engine.
// ----------------------------------------------------------------------------
package rse_pkg;

  // Default table depth (operations held in time order)
  localparam int unsigned MAX_OPS_DEF = 64;

  // Payload widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned VAL_W  = 32;

  // Command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_DEL = 1'b1;

  // Result of the shared timestamp comparator
  typedef struct packed {
    logic le;  // entry time <= operand time (signed order)
    logic eq;  // entry time == operand time
  } rse_cmp_t;

endpackage

/* rtl/rse_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_if
// Valid/ready channels of the engine: command input and stack result output.
// ----------------------------------------------------------------------------

interface rse_in_if
  import rse_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [TIME_W-1:0] op_time;
  logic                     is_push;
  logic signed [VAL_W-1:0]  push_value;

  modport source (output valid, cmd, op_time, is_push, push_value, input ready);
  modport sink   (input valid, cmd, op_time, is_push, push_value, output ready);
endinterface

interface rse_out_if
  import rse_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] stack_value;
  logic                    stack_empty;
  logic                    not_found;
  logic                    table_full;
  logic                    last;

  modport source (output valid, stack_value, stack_empty, not_found, table_full, last,
                  input ready);
  modport sink   (input valid, stack_value, stack_empty, not_found, table_full, last,
                  output ready);
endinterface

/* rtl/rse_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rse_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rse_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_cmp
// Shared timestamp comparator: signed order and equality of two times.
// ----------------------------------------------------------------------------
module rse_cmp
  import rse_pkg::*;
(
  input  logic signed [TIME_W-1:0] entry_time_i,
  input  logic signed [TIME_W-1:0] op_time_i,
  output rse_cmp_t                 res_o
);

  // Compare as signed numbers; equality on raw bits
  always_comb begin
    res_o.le = (entry_time_i <= op_time_i);
    res_o.eq = (entry_time_i == op_time_i);
  end

endmodule

/* rtl/retroactive_stack_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retroactive_stack_engine_core
// Time-ordered push/pop table with full replay and bottom-first stack output.
// ----------------------------------------------------------------------------
// Each command (add or delete at a signed timestamp) edits a table of up to
// MAX_OPS operations held in time order, replays the whole table on an empty
// stack and streams the stack out bottom first, one transfer per entry with
// last on the final one; an empty stack gives a single transfer with
// stack_empty set. The block takes one command at a time and drops ready until
// the last result transfer. A command scans the table up to its position, moves
// the entries behind it for an insert or delete, replays the table and emits
// the final stack; each step handles one entry per cycle (the emit step only
// while out_o.ready is high), through the single read and single write port of
// each memory and one timestamp comparator.
// ----------------------------------------------------------------------------
module retroactive_stack_engine_core
  import rse_pkg::*;
#(
  parameter int unsigned MAX_OPS = MAX_OPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rse_in_if.sink    in_i,
  rse_out_if.source out_o
);

  localparam int unsigned AW    = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int unsigned CW    = $clog2(MAX_OPS + 1);
  localparam int unsigned TBL_W = TIME_W + 1 + VAL_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_SHIFT_ADD = 3'd2;
  localparam logic [2:0] S_SHIFT_DEL = 3'd3;
  localparam logic [2:0] S_WRITE     = 3'd4;
  localparam logic [2:0] S_PRIME     = 3'd5;
  localparam logic [2:0] S_REPLAY    = 3'd6;
  localparam logic [2:0] S_EMIT      = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            depth_q, depth_d;
  logic                     cmd_q, cmd_d;
  logic signed [TIME_W-1:0] time_q, time_d;
  logic                     push_q, push_d;
  logic signed [VAL_W-1:0]  value_q, value_d;
  logic                     nf_q, nf_d;
  logic                     full_q, full_d;

  logic                     tbl_we;
  logic [AW-1:0]            tbl_waddr;
  logic [TBL_W-1:0]         tbl_wdata;
  logic [CW-1:0]            tbl_rsel;
  logic [TBL_W-1:0]         tbl_rdata;
  logic                     stk_we;
  logic [VAL_W-1:0]         stk_rdata;

  logic signed [TIME_W-1:0] ent_time;
  logic                     ent_push;
  rse_cmp_t                 cmp;
  logic                     in_xfer;
  logic                     out_last;

  assign ent_time = tbl_rdata[TBL_W-1 -: TIME_W];
  assign ent_push = tbl_rdata[VAL_W];

  // Operation table and replay stack
  rse_ram #(.WIDTH(TBL_W), .DEPTH(MAX_OPS)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_rsel[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  rse_ram #(.WIDTH(VAL_W), .DEPTH(MAX_OPS)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[AW-1:0]),
    .wdata_i (tbl_rdata[VAL_W-1:0]),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  // Timestamp comparator shared by the insert and delete scans
  rse_cmp u_cmp (
    .entry_time_i (ent_time),
    .op_time_i    (time_q),
    .res_o        (cmp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Result channel: stack entry from the stack read register
  assign out_last          = (depth_q == '0) || (idx_q + CW'(1) == depth_q);
  assign out_o.valid       = (state_q == S_EMIT);
  assign out_o.stack_value = (depth_q == '0) ? '0 : $signed(stk_rdata);
  assign out_o.stack_empty = (depth_q == '0);
  assign out_o.not_found   = nf_q;
  assign out_o.table_full  = full_q;
  assign out_o.last        = out_last;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    count_d   = count_q;
    depth_d   = depth_q;
    cmd_d     = cmd_q;
    time_d    = time_q;
    push_d    = push_q;
    value_d   = value_q;
    nf_d      = nf_q;
    full_d    = full_q;
    tbl_we    = 1'b0;
    tbl_waddr = idx_q[AW-1:0];
    tbl_wdata = tbl_rdata;
    stk_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d   = in_i.cmd;
          time_d  = in_i.op_time;
          push_d  = in_i.is_push;
          value_d = in_i.push_value;
          nf_d    = 1'b0;
          full_d  = (in_i.cmd == CMD_ADD) && (count_q == CW'(MAX_OPS));
          idx_d   = '0;
          state_d = ((in_i.cmd == CMD_ADD) && (count_q == CW'(MAX_OPS))) ? S_PRIME : S_SCAN;
        end
      end

      // Walk the table for the insert point or the first matching time
      S_SCAN: begin
        if (idx_q == count_q) begin
          if (cmd_q == CMD_ADD) begin
            pos_d   = count_q;
            state_d = S_WRITE;
          end else begin
            nf_d    = 1'b1;
            state_d = S_PRIME;
          end
        end else if ((cmd_q == CMD_ADD) && !cmp.le) begin
          pos_d   = idx_q;
          idx_d   = count_q;
          state_d = S_SHIFT_ADD;
        end else if ((cmd_q == CMD_DEL) && cmp.eq) begin
          pos_d = idx_q;
          if (idx_q + CW'(1) == count_q) begin
            count_d = count_q - CW'(1);
            state_d = S_PRIME;
          end else begin
            state_d = S_SHIFT_DEL;
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      // Move entries up one place, top first
      S_SHIFT_ADD: begin
        tbl_we = 1'b1;
        if (idx_q - CW'(1) == pos_q) begin
          state_d = S_WRITE;
        end else begin
          idx_d = idx_q - CW'(1);
        end
      end

      // Move entries down one place over the deleted one
      S_SHIFT_DEL: begin
        tbl_we = 1'b1;
        if (idx_q + CW'(2) == count_q) begin
          count_d = count_q - CW'(1);
          state_d = S_PRIME;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      // Store the new operation at its place
      S_WRITE: begin
        tbl_we    = 1'b1;
        tbl_waddr = pos_q[AW-1:0];
        tbl_wdata = {time_q, push_q, (push_q ? value_q : VAL_W'(0))};
        count_d   = count_q + CW'(1);
        state_d   = S_PRIME;
      end

      // Issue the first table read of the replay
      S_PRIME: begin
        idx_d   = '0;
        depth_d = '0;
        state_d = S_REPLAY;
      end

      // Replay one operation per cycle on the stack
      S_REPLAY: begin
        if (idx_q == count_q) begin
          idx_d   = '0;
          state_d = S_EMIT;
        end else begin
          if (ent_push) begin
            if (depth_q < CW'(MAX_OPS)) begin
              stk_we  = 1'b1;
              depth_d = depth_q + CW'(1);
            end
          end else if (depth_q != '0) begin
            depth_d = depth_q - CW'(1);
          end
          idx_d = idx_q + CW'(1);
        end
      end

      // Stream the stack out, bottom first
      S_EMIT: begin
        if (out_o.ready) begin
          if (out_last) begin
            idx_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Table read address for the next cycle's entry
  always_comb begin
    case (state_d)
      S_SHIFT_ADD: tbl_rsel = idx_d - CW'(1);
      S_SHIFT_DEL: tbl_rsel = idx_d + CW'(1);
      default:     tbl_rsel = idx_d;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      count_q <= '0;
      depth_q <= '0;
      cmd_q   <= CMD_ADD;
      nf_q    <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      depth_q <= depth_d;
      cmd_q   <= cmd_d;
      nf_q    <= nf_d;
      full_q  <= full_d;
    end
  end

  // Command payload
  always_ff @(posedge clk_i) begin
    time_q  <= time_d;
    push_q  <= push_d;
    value_q <= value_d;
  end

  // Checks
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("command taken while results pending");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_OPS))
    else $error("table count beyond depth");

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPLAY) |-> (depth_q <= idx_q))
    else $error("stack deeper than replayed operations");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.not_found && out_o.table_full))
    else $error("not_found and table_full together");

  a_shift_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_ADD) |-> (idx_q > pos_q) && (idx_q <= count_q))
    else $error("insert shift out of range");

  a_full_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRIME) && full_q |-> $stable(count_q))
    else $error("table changed on rejected add");

endmodule
